### hw/rtl/obl_pkg.sv
// ----------------------------------------------------------------------------
// obl_pkg: shared types and constants for the ordered byte list
// Command and status codes, list sizing and the cell control bundle.
// ----------------------------------------------------------------------------
package obl_pkg;

  localparam int CAPACITY = 16;
  localparam int LEN_W    = 5;                 // length and position fields
  localparam int IDX_W    = $clog2(CAPACITY);  // cell index
  localparam int DATA_W   = 8;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_PUSH_HEAD = 3'd1,
    CMD_INSERT_AT = 3'd2,
    CMD_POP_TAIL  = 3'd3,
    CMD_POP_HEAD  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              pop_head;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] data;
  } cell_ctrl_t;

  // per-command result info for the output stage
  typedef struct packed {
    status_e          status;
    logic [LEN_W-1:0] len;
    logic             pop_tail;
    logic             pop_head;
    logic [IDX_W-1:0] tail_idx;
  } cmd_res_t;

endpackage

### hw/rtl/ordered_byte_list_top.sv
// ----------------------------------------------------------------------------
// ordered_byte_list_top: bounded ordered list of bytes
// Append, head insert, positional insert, tail and head removal on a cell row.
// ----------------------------------------------------------------------------
// result: the result beat is registered and appears in the cycle after the command beat is taken
// throughput: one command per cycle while in_ready_o is high; every cell of the row updates in that cycle
// a held result beat stalls new commands only while out_ready_i is low
// reset: list empty, no result pending; cell contents undefined until written
module ordered_byte_list_top import obl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        command_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic [LEN_W-1:0]  position_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] removed_data_o,
  output logic [1:0]        status_o,
  output logic [LEN_W-1:0]  length_o
);

  logic              accept;
  cell_ctrl_t        cell_ctrl;
  cmd_res_t          res;
  logic [DATA_W-1:0] cells [CAPACITY];
  logic [DATA_W-1:0] removed;

  logic              out_valid_q;
  logic [DATA_W-1:0] removed_q;
  logic [1:0]        status_q;
  logic [LEN_W-1:0]  length_q;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  obl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (command_i),
    .data_i     (data_i),
    .position_i (position_i),
    .ctrl_o     (cell_ctrl),
    .res_o      (res)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = cells[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = cells[k];
    end else begin : g_inner
      assign right = cells[k+1];
    end
    obl_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .idx_i   (IDX_W'(k)),
      .left_i  (left),
      .right_i (right),
      .q_o     (cells[k])
    );
  end

  always_comb begin
    removed = '0;
    if (res.pop_tail) begin
      removed = cells[res.tail_idx];
    end else if (res.pop_head) begin
      removed = cells[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed;
      status_q  <= res.status;
      length_q  <= res.len;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign removed_data_o = removed_q;
  assign status_o       = status_q;
  assign length_o       = length_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> length_o <= LEN_W'(CAPACITY))
    else $error("length beyond capacity");

  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> removed_data_o == '0 && length_o == '0)
    else $error("empty removal beat carries data or length");

  a_full_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> length_o == LEN_W'(CAPACITY))
    else $error("full status with list not full");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("command beat produced no result beat");

endmodule

### hw/rtl/obl_cell.sv
// ----------------------------------------------------------------------------
// obl_cell: one slot of the shift-insert row
// Holds one byte; takes its left neighbor, its right neighbor or the new byte.
// ----------------------------------------------------------------------------
module obl_cell import obl_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] q_o
);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (idx_i > ctrl_i.slot) begin
        data_d = left_i;
      end else if (idx_i == ctrl_i.slot) begin
        data_d = ctrl_i.data;
      end
    end else if (ctrl_i.pop_head) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

### hw/rtl/obl_ctrl.sv
// ----------------------------------------------------------------------------
// obl_ctrl: command decode and element count
// Turns a command into the row's control bundle and tracks the list length.
// ----------------------------------------------------------------------------
module obl_ctrl import obl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [2:0]        command_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic [LEN_W-1:0]  position_i,
  output cell_ctrl_t        ctrl_o,
  output cmd_res_t          res_o
);

  logic [LEN_W-1:0] count_q, count_d;
  logic [LEN_W-1:0] slot;
  logic             do_ins;
  logic             full, empty;
  cmd_e             cmd;

  assign cmd   = cmd_e'(command_i);
  assign full  = (count_q == LEN_W'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    slot            = count_q;
    do_ins          = 1'b0;
    count_d         = count_q;
    res_o.status    = ST_OK;
    res_o.pop_tail  = 1'b0;
    res_o.pop_head  = 1'b0;
    res_o.tail_idx  = IDX_W'(count_q - 1'b1);
    unique case (cmd)
      CMD_APPEND: begin
        do_ins = 1'b1;
      end
      CMD_PUSH_HEAD: begin
        do_ins = 1'b1;
        slot   = '0;
      end
      CMD_INSERT_AT: begin
        do_ins = 1'b1;
        // position zero or past the tail appends
        if (position_i != '0 && position_i <= count_q) begin
          slot = LEN_W'(position_i - 1'b1);
        end
      end
      CMD_POP_TAIL: begin
        if (empty) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.pop_tail = 1'b1;
          count_d        = LEN_W'(count_q - 1'b1);
        end
      end
      CMD_POP_HEAD: begin
        if (empty) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.pop_head = 1'b1;
          count_d        = LEN_W'(count_q - 1'b1);
        end
      end
      default: ;
    endcase
    if (do_ins) begin
      if (full) begin
        res_o.status = ST_FULL;
      end else begin
        count_d = LEN_W'(count_q + 1'b1);
      end
    end
    res_o.len = count_d;
  end

  always_comb begin
    ctrl_o.ins      = accept_i & do_ins & ~full;
    ctrl_o.pop_head = accept_i & res_o.pop_head;
    ctrl_o.slot     = slot[IDX_W-1:0];
    ctrl_o.data     = data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for ordered_byte_list_top
// Drives list commands through the valid/ready input channel, tracks the
// expected list contents and checks every result beat on the output channel.
// ----------------------------------------------------------------------------
module tb;
  import obl_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_BEATS = 1200;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam longint WATCHDOG_NS = 2_000_000;

  // tracks list contents and the result beats still owed by the block
  class byte_list_tracker;
    typedef struct {
      logic [DATA_W-1:0] removed;
      logic [1:0]        status;
      logic [LEN_W-1:0]  length;
    } list_result_t;

    logic [DATA_W-1:0] cells [CAPACITY];
    int                held;
    list_result_t      owed[$];
    int                mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    function void note_command(logic [2:0] cmd, logic [DATA_W-1:0] b,
                               logic [LEN_W-1:0] pos);
      list_result_t r;
      int slot;
      int k;
      r.removed = '0;
      r.status  = ST_OK;
      case (cmd)
        CMD_APPEND, CMD_PUSH_HEAD, CMD_INSERT_AT: begin
          if (held >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            if (cmd == CMD_PUSH_HEAD) slot = 0;
            else if (cmd == CMD_INSERT_AT && pos != 0 && pos <= held) slot = pos - 1;
            else slot = held;
            for (k = held; k > slot; k--) cells[k] = cells[k-1];
            cells[slot] = b;
            held++;
          end
        end
        CMD_POP_TAIL: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            held--;
            r.removed = cells[held];
          end
        end
        CMD_POP_HEAD: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.removed = cells[0];
            for (k = 1; k < held; k++) cells[k-1] = cells[k];
            held--;
          end
        end
        default: ;
      endcase
      r.length = held[LEN_W-1:0];
      owed.push_back(r);
    endfunction

    function void check_result(logic [DATA_W-1:0] removed, logic [1:0] status,
                               logic [LEN_W-1:0] length);
      list_result_t exp;
      if (owed.size() == 0) begin
        $error("result beat with nothing outstanding: removed_data %0h status %0d length %0d",
               removed, status, length);
        mismatches++;
        return;
      end
      exp = owed.pop_front();
      if (removed !== exp.removed) begin
        $error("removed_data: expected %0h, got %0h", exp.removed, removed);
        mismatches++;
      end
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        mismatches++;
      end
      if (length !== exp.length) begin
        $error("length: expected %0d, got %0d", exp.length, length);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [2:0]        command_i;
  logic [DATA_W-1:0] data_i;
  logic [LEN_W-1:0]  position_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [DATA_W-1:0] removed_data_o;
  logic [1:0]        status_o;
  logic [LEN_W-1:0]  length_o;

  byte_list_tracker tracker = new();
  bit rx_idle_en;
  bit hold_off_req;

  ordered_byte_list_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .data_i         (data_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .removed_data_o (removed_data_o),
    .status_o       (status_o),
    .length_o       (length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

  // both channels sampled at the same edge so a command is noted before its result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.note_command(command_i, data_i, position_i);
      if (out_valid_o && out_ready_i)
        tracker.check_result(removed_data_o, status_o, length_o);
    end
  end

  // result side: random ready bursts, plus one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [DATA_W-1:0] b,
                              input logic [LEN_W-1:0] pos);
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    data_i     <= b;
    position_i <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause_sender(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_list_settled();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
  endtask

  initial begin
    cmd_e grow_cmds [4] = '{CMD_APPEND, CMD_PUSH_HEAD, CMD_INSERT_AT, CMD_INSERT_AT};
    logic [2:0] cmd;
    logic [LEN_W-1:0] pos;
    bit grow_bias;
    bit tx_idle_en;
    int quiet_until;
    int roll;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    command_i    <= CMD_APPEND;
    data_i       <= '0;
    position_i   <= '0;
    rx_idle_en   = 1'b1;
    hold_off_req = 1'b0;
    quiet_until  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // removals on an empty list, inserts while it is short, and the spare command codes
    send_command(CMD_POP_TAIL, 8'hFF, 5'd0);
    send_command(CMD_POP_HEAD, 8'hFF, 5'd31);
    send_command(CMD_INSERT_AT, 8'hA5, 5'd31);
    send_command(CMD_INSERT_AT, 8'h00, 5'd0);
    send_command(CMD_INSERT_AT, 8'hFF, 5'd1);
    send_command(CMD_INSERT_AT, 8'h5A, 5'd2);
    send_command(CMD_PUSH_HEAD, 8'h80, 5'd0);
    send_command(CMD_APPEND, 8'h7F, 5'd16);
    send_command(CMD_SPARE_LO, 8'h00, 5'd0);
    send_command(CMD_SPARE_HI, 8'hFF, 5'd31);
    // fill up, then every insert flavor against a full list, then one tail and one head removal
    for (int n = 6; n < CAPACITY; n++) send_command(CMD_APPEND, 8'(8'h10 + n), 5'd0);
    send_command(CMD_APPEND, 8'hEE, 5'd0);
    send_command(CMD_PUSH_HEAD, 8'hEE, 5'd0);
    send_command(CMD_INSERT_AT, 8'hEE, 5'd1);
    send_command(CMD_POP_TAIL, 8'h00, 5'd0);
    send_command(CMD_POP_HEAD, 8'h00, 5'd0);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      grow_bias  = ((i / 40) % 2) == 0;
      tx_idle_en = (i < RANDOM_BEATS - 200) && ((i / 100) % 3 != 2) && (i >= quiet_until);
      rx_idle_en = (i < RANDOM_BEATS - 200) && ((i / 150) % 3 != 1);

      if (i == 300) begin
        // receiver stalls long while commands keep coming
        hold_off_req = 1'b1;
        quiet_until  = i + 30;
        tx_idle_en   = 1'b0;
      end
      if (i == 700) wait_list_settled();

      roll = $urandom_range(0, 99);
      if (roll < 3) cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      else if ((roll < 73) == grow_bias) cmd = grow_cmds[2'($urandom_range(0, 3))];
      else cmd = ($urandom_range(0, 1) != 0) ? CMD_POP_TAIL : CMD_POP_HEAD;

      if ($urandom_range(0, 3) == 0) pos = LEN_W'($urandom_range(0, 31));
      else pos = LEN_W'($urandom_range(0, CAPACITY + 1));

      send_command(cmd, 8'($urandom_range(0, 255)), pos);
      if (tx_idle_en && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 10));
    end

    wait_list_settled();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
